>>> rtl/ahfe_pkg.sv
package ahfe_pkg;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] HEX_DIGIT = 8'h30;
  localparam logic [7:0] HEX_ALPHA = 8'h37;
  localparam logic [3:0] NIBBLE_TEN = 4'hA;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic       first;
    logic       last;
    logic [7:0] hi_char;
    logic [7:0] lo_char;
    logic [7:0] ck_hi_char;
    logic [7:0] ck_lo_char;
  } job_t;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_COLON = 8'b0000_0010,
    PH_HI    = 8'b0000_0100,
    PH_LO    = 8'b0000_1000,
    PH_CKH   = 8'b0001_0000,
    PH_CKL   = 8'b0010_0000,
    PH_CR    = 8'b0100_0000,
    PH_LF    = 8'b1000_0000
  } phase_t;

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    logic [7:0] wide;
    wide = {4'h0, v};
    if (v >= NIBBLE_TEN) begin
      return wide + HEX_ALPHA;
    end else begin
      return wide + HEX_DIGIT;
    end
  endfunction

endpackage

>>> rtl/ahfe_if.sv
interface ahfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ahfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       end_of_frame;

  modport source (output valid, output ascii_char, output end_of_frame, input ready);
  modport sink (input valid, input ascii_char, input end_of_frame, output ready);
endinterface

>>> rtl/ahfe_front.sv
module ahfe_front
  import ahfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       q_full,
  output logic       in_ready,
  output logic       push,
  output job_t       push_job
);

  logic       mid_frame;
  logic [7:0] char_sum;
  logic [7:0] sum_next;
  logic [7:0] ck;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_job.first   = !mid_frame;
    push_job.last    = last_byte;
    push_job.hi_char = nibble_char(data_byte[7:4]);
    push_job.lo_char = nibble_char(data_byte[3:0]);
    sum_next = char_sum + push_job.hi_char + push_job.lo_char;
    ck = 8'h00 - sum_next;
    push_job.ck_hi_char = nibble_char(ck[7:4]);
    push_job.ck_lo_char = nibble_char(ck[3:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_frame <= 1'b0;
      char_sum  <= 8'h00;
    end else if (push) begin
      if (last_byte) begin
        mid_frame <= 1'b0;
        char_sum  <= 8'h00;
      end else begin
        mid_frame <= 1'b1;
        char_sum  <= sum_next;
      end
    end
  end

endmodule

>>> rtl/ahfe_queue.sv
module ahfe_queue
  import ahfe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_COUNT);
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/ahfe_back.sv
module ahfe_back
  import ahfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] ascii_char,
  output logic       end_of_frame
);

  phase_t     phase;
  phase_t     phase_cur;
  phase_t     phase_next;
  logic       load;
  logic       done;
  logic [7:0] char_next;

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && done;

  always_comb begin
    if (phase == PH_IDLE) begin
      phase_cur = head_job.first ? PH_COLON : PH_HI;
    end else begin
      phase_cur = phase;
    end
  end

  always_comb begin
    char_next  = CH_LF;
    phase_next = PH_IDLE;
    done       = 1'b0;
    unique case (phase_cur)
      PH_COLON: begin
        char_next  = CH_COLON;
        phase_next = PH_HI;
      end
      PH_HI: begin
        char_next  = head_job.hi_char;
        phase_next = PH_LO;
      end
      PH_LO: begin
        char_next  = head_job.lo_char;
        phase_next = head_job.last ? PH_CKH : PH_IDLE;
        done       = !head_job.last;
      end
      PH_CKH: begin
        char_next  = head_job.ck_hi_char;
        phase_next = PH_CKL;
      end
      PH_CKL: begin
        char_next  = head_job.ck_lo_char;
        phase_next = PH_CR;
      end
      PH_CR: begin
        char_next  = CH_CR;
        phase_next = PH_LF;
      end
      PH_LF: begin
        char_next  = CH_LF;
        phase_next = PH_IDLE;
        done       = 1'b1;
      end
      default: begin
        char_next  = CH_LF;
        phase_next = PH_IDLE;
        done       = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else if (load) begin
      phase     <= phase_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ascii_char   <= char_next;
      end_of_frame <= (phase_cur == PH_LF);
    end
  end

  // The closing LF must always be the character that carries the frame mark.
  a_eof_is_lf: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> ascii_char == CH_LF)
    else $error("frame end marked on a character other than LF");

  // A word is released from the queue in the same cycle as its final character is loaded.
  a_pop_done: assert property (@(posedge clk) disable iff (rst)
    pop |=> phase == PH_IDLE)
    else $error("sequencer not idle after releasing a word");

  // A stalled output holds its character.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ascii_char) && $stable(end_of_frame))
    else $error("output character changed under stall");

  // The sequencer is only mid-word while a word is at the queue head.
  a_busy_has_head: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> head_valid)
    else $error("sequencer busy with an empty queue");

endmodule

>>> rtl/ascii_hex_frame_encoder.sv
// ASCII hex frame encoder.
// The payload channel takes one frame byte per word together with a last-byte
// mark. The chars channel delivers one ASCII character per word: a colon
// before the first byte of each frame, two upper-case hex characters per byte,
// and after the last byte two checksum characters, CR and LF. The LF carries
// end_of_frame. The checksum is the two's complement of the 8-bit sum of all
// hex character codes of the frame's payload.
// An accepted byte is classified and its checksum work done in the same cycle,
// then it waits in a small queue of QUEUE_DEPTH entries (at least 2). The first
// character of a byte is loaded from the queue head into the output register,
// which drives the chars channel. The output register sends one character
// per cycle while the receiver is ready, so a byte yields 2 to 7 characters:
// 2 for an inner byte, 3 with the colon, 4 more after a last byte. Payload
// ready stays high while the queue has room, so bytes flow back to back.
// When the receiver stalls, the current character holds, the queue fills and
// payload ready drops. Reset clears the queue, the output valid and the
// framing state, so the next byte starts a new frame.
module ascii_hex_frame_encoder
  import ahfe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  ahfe_in_if.sink     payload,
  ahfe_out_if.source  chars
);

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  ahfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (payload.valid),
    .data_byte (payload.data_byte),
    .last_byte (payload.last_byte),
    .q_full    (q_full),
    .in_ready  (payload.ready),
    .push      (push),
    .push_job  (push_job)
  );

  ahfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  ahfe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .out_valid    (chars.valid),
    .out_ready    (chars.ready),
    .ascii_char   (chars.ascii_char),
    .end_of_frame (chars.end_of_frame)
  );

endmodule
